// ===== design/thermistor_temperature_classifier_defines.svh =====
// assertion macros for the thermistor temperature classifier
// no dependencies; included by the top level only
`ifndef THERMISTOR_TEMPERATURE_CLASSIFIER_DEFINES_SVH
`define THERMISTOR_TEMPERATURE_CLASSIFIER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define TTC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ttc assertion failed");

// condition implies a fact in the next cycle
`define TTC_ASSERT_NEXT(lbl, clk, rstn, cond, fact) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (fact)) \
    else $error("ttc assertion failed");

`else

`define TTC_ASSERT(lbl, clk, rstn, prop)
`define TTC_ASSERT_NEXT(lbl, clk, rstn, cond, fact)

`endif

`endif

// ===== design/ttc_pkg.sv =====
// constants and types for the thermistor temperature classifier
// no dependencies; imported by the top level
package ttc_pkg;

  localparam int unsigned ADC_W      = 10;
  localparam int unsigned BOUND_W    = ADC_W + 1;
  localparam int unsigned ADC_FULL   = 1023;
  localparam int unsigned FIXED_OHMS = 10000;
  localparam int unsigned NUM_THRESH = 40;
  localparam int unsigned CODE_W     = 6;
  localparam int unsigned CLASS_W    = 2;
  localparam int unsigned LIMIT_W    = 6;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned GROUP_SZ   = 8;
  localparam int unsigned NUM_GROUPS = NUM_THRESH / GROUP_SZ;
  localparam int unsigned PART_W     = 4;

  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RESET  = 6'd22;
  localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RESET = 6'd26;
  localparam logic [CODE_W-1:0]  CODE_MAX         = 6'd40;

  // register indexes on the config port
  localparam logic [CFG_ADDR_W-1:0] REG_LOW_LIMIT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH_LIMIT = 2'd1;

  // descending resistance thresholds in ohms
  localparam int unsigned TEMP_THRESH [NUM_THRESH] = '{
    31308, 29749, 28276, 26885, 25570, 24327, 23152, 22141,
    20989, 19993, 19051, 18158, 17312, 16511, 15751, 15031,
    14347, 13698, 13083, 12499, 11944, 11417, 10916, 10440,
    10000,  9556,  9147,  8758,  8387,  8034,  7700,  7377,
     7072,  6781,  6504,  6239,  5987,  5746,  5517,  5298
  };

  typedef enum logic [CLASS_W-1:0] {
    CLASS_BELOW  = 2'd0,
    CLASS_WITHIN = 2'd1,
    CLASS_ABOVE  = 2'd2
  } temp_class_t;

endpackage

// ===== design/thermistor_temperature_classifier.sv =====
// thermistor divider sample to temperature code and class, four-stage pipeline
// depends on ttc_pkg and thermistor_temperature_classifier_defines.svh
//
//  port group   direction  payload (low bit first)
//  in_*         slave      in_tdata: adc_sample[9:0], zeros [15:10]
//  out_*        master     out_tdata: temp_code[5:0], temp_class[7:6]
//  cfg_*        write      cfg_addr: 0 low_limit, 1 high_limit; cfg_wdata[5:0]
//
// one sample per cycle while the output is not stalled; each item leaves after stage 4.
// stage 1 compares the sample against 40 precomputed sample bounds (one per
// resistance threshold), stage 2 counts groups of eight, stage 3 sums the
// groups, stage 4 classifies against the limits and holds the result.
// each stage has its own valid bit and advances when the next one is free,
// so bubbles close up behind a stalled output. rst_n is synchronous and
// clears the valid bits and sets the limits to 22 and 26.
`include "thermistor_temperature_classifier_defines.svh"

module thermistor_temperature_classifier
  import ttc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: adc_sample[9:0], zero fill [15:10]
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,
  // out_tdata: temp_code[5:0], temp_class[7:6]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [LIMIT_W-1:0]    cfg_wdata
);

  // count of set bits in one group of compare results
  function automatic logic [PART_W-1:0] count_group(input logic [GROUP_SZ-1:0] bits);
    logic [PART_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < GROUP_SZ; i++) begin
      acc = acc + PART_W'(bits[i]);
    end
    return acc;
  endfunction

  logic [LIMIT_W-1:0]    low_limit_r;
  logic [LIMIT_W-1:0]    high_limit_r;

  logic                  v1_r, v2_r, v3_r, out_valid_r;
  logic                  rdy1, rdy2, rdy3, rdy4;
  logic [ADC_W-1:0]      adc_sample;
  logic [NUM_THRESH-1:0] thermo_nxt, thermo_r;
  logic [PART_W-1:0]     part_nxt [NUM_GROUPS];
  logic [PART_W-1:0]     part_r   [NUM_GROUPS];
  logic [CODE_W-1:0]     code_nxt, code_r;
  temp_class_t           class_nxt;
  logic [CODE_W-1:0]     out_code_r;
  temp_class_t           out_class_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_limit_r  <= LOW_LIMIT_RESET;
      high_limit_r <= HIGH_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LOW_LIMIT:  low_limit_r  <= cfg_wdata;
        REG_HIGH_LIMIT: high_limit_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // per-stage handshake, a stage loads when empty or when it drains
  assign rdy4      = !out_valid_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  assign adc_sample = in_tdata[ADC_W-1:0];

  // stage 1: floor(10000*a/(1023-a)) <= T is the same as a < bound(T)
  for (genvar g = 0; g < NUM_THRESH; g++) begin : g_cmp
    localparam int unsigned BOUND =
      ((TEMP_THRESH[g] + 1) * ADC_FULL + TEMP_THRESH[g] + FIXED_OHMS) /
      (TEMP_THRESH[g] + FIXED_OHMS + 1);
    localparam logic [BOUND_W-1:0] BOUND_V = BOUND[BOUND_W-1:0];
    assign thermo_nxt[g] = ({1'b0, adc_sample} < BOUND_V);
  end

  // stage 2: partial counts
  always_comb begin
    for (int j = 0; j < NUM_GROUPS; j++) begin
      part_nxt[j] = count_group(thermo_r[j*GROUP_SZ +: GROUP_SZ]);
    end
  end

  // stage 3: sum of partial counts
  always_comb begin
    code_nxt = '0;
    for (int j = 0; j < NUM_GROUPS; j++) begin
      code_nxt = code_nxt + CODE_W'(part_r[j]);
    end
  end

  // stage 4: below test first, then above
  always_comb begin
    if (code_r < low_limit_r) begin
      class_nxt = CLASS_BELOW;
    end else if (code_r > high_limit_r) begin
      class_nxt = CLASS_ABOVE;
    end else begin
      class_nxt = CLASS_WITHIN;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r        <= in_tvalid;
      if (rdy2) v2_r        <= v1_r;
      if (rdy3) v3_r        <= v2_r;
      if (rdy4) out_valid_r <= v3_r;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) thermo_r <= thermo_nxt;
    if (rdy2 && v1_r)      part_r   <= part_nxt;
    if (rdy3 && v2_r)      code_r   <= code_nxt;
    if (rdy4 && v3_r) begin
      out_code_r  <= code_r;
      out_class_r <= class_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_class_r, out_code_r};

  // compare results form a run of ones from bit 0
  `TTC_ASSERT(a_thermo_run, clk, rst_n,
    v1_r |-> ((thermo_r & (thermo_r + NUM_THRESH'(1))) == '0))
  // code never beyond the table
  `TTC_ASSERT(a_code_range, clk, rst_n, out_valid_r |-> (out_code_r <= CODE_MAX))
  // input held off only when every stage is full behind a stalled output
  `TTC_ASSERT(a_stall_full, clk, rst_n,
    !in_tready |-> (v1_r && v2_r && v3_r && out_valid_r && !out_tready))
  // a sum taken into stage 3 equals the sum of the stage 2 partial counts
  `TTC_ASSERT_NEXT(a_sum_len, clk, rst_n, (rdy3 && v2_r),
    (code_r == $past(code_nxt)))

endmodule

// ===== tb/tb_thermistor_temperature_classifier.sv =====
`timescale 1ns / 100ps
// self-checking testbench for thermistor_temperature_classifier: streams adc
// samples, predicts temperature code and class per item, checks results in order
// depends on ttc_pkg and the thermistor_temperature_classifier top level
module tb_thermistor_temperature_classifier
  import ttc_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned HOLD_CYCLES  = 64;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS  = 200;
  localparam int unsigned DIRECTED_N   = 20;

  // register indexes the block does not implement
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_3 = 2'd3;

  // bit extremes, full scale, table edges, code 28 band, lowest threshold
  localparam logic [ADC_W-1:0] DIRECTED_SAMPLES [DIRECTED_N] = '{
    10'd0,   10'd1,   10'd1023, 10'd1022, 10'd341, 10'd682, 10'd511,
    10'd512, 10'd775, 10'd776,  10'd466,  10'd467, 10'd477, 10'd478,
    10'd354, 10'd355, 10'd353,  10'd600,  10'd700, 10'd450
  };

  typedef struct packed {
    logic [CODE_W-1:0] code;
    temp_class_t       cls;
  } temp_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata   = '0;   // adc_sample[9:0], zero fill [15:10]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;         // temp_code[5:0], temp_class[7:6]
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [LIMIT_W-1:0]    cfg_wdata  = '0;

  // predictor copy of the limit registers
  logic [LIMIT_W-1:0] low_lim  = LOW_LIMIT_RESET;
  logic [LIMIT_W-1:0] high_lim = HIGH_LIMIT_RESET;

  logic [ADC_W-1:0] sample_q[$];
  temp_result_t     temp_exp_q[$];

  bit          in_took        = 1'b0;
  bit          out_took       = 1'b0;
  int unsigned send_gap_max   = 4;
  int unsigned recv_stall_max = 4;
  int unsigned send_wait      = 0;
  int unsigned recv_wait      = 0;
  int unsigned holds_asked    = 0;
  int unsigned holds_done     = 0;
  int unsigned hold_left      = 0;
  int unsigned fail_count     = 0;
  int unsigned cycle_count    = 0;

  thermistor_temperature_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial forever #6 clk = ~clk;

  // resistance from the divider, then count thresholds at or above it
  function automatic temp_result_t classify_sample(logic [ADC_W-1:0] adc);
    temp_result_t res;
    int unsigned  ohms;
    logic [CODE_W-1:0] hits;
    hits = '0;
    if (adc < ADC_FULL) begin
      ohms = (FIXED_OHMS * adc) / (ADC_FULL - adc);
      for (int k = 0; k < NUM_THRESH; k++) begin
        if (ohms <= TEMP_THRESH[k]) hits++;
      end
    end
    res.code = hits;
    // below test wins when the limits cross
    if (hits < low_lim) res.cls = CLASS_BELOW;
    else if (hits > high_lim) res.cls = CLASS_ABOVE;
    else res.cls = CLASS_WITHIN;
    return res;
  endfunction

  // input driver: one item at a time, random gap after each
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (send_wait > 0) begin
        in_tvalid <= 1'b0;
        send_wait--;
      end else if (sample_q.size() != 0) begin
        in_tdata  <= {{(16-ADC_W){1'b0}}, sample_q.pop_front()};
        in_tvalid <= 1'b1;
        send_wait = $urandom_range(0, send_gap_max);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: random stall per item, long hold on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      out_tready <= 1'b0;
    end else if (out_took || !out_tready) begin
      if (out_took) recv_wait = $urandom_range(0, recv_stall_max);
      if (recv_wait > 0) begin
        out_tready <= 1'b0;
        recv_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    temp_result_t want;
    in_took  <= rst_n && in_tvalid && in_tready;
    out_took <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready)
      temp_exp_q.push_back(classify_sample(in_tdata[ADC_W-1:0]));
    if (rst_n && out_tvalid && out_tready) begin
      if (temp_exp_q.size() == 0) begin
        $error("result with nothing expected: tdata 0x%02h", out_tdata);
        fail_count++;
      end else begin
        want = temp_exp_q.pop_front();
        if (out_tdata[5:0] !== want.code) begin
          $error("temp_code mismatch: expected %0d, actual %0d", want.code, out_tdata[5:0]);
          fail_count++;
        end
        if (out_tdata[7:6] !== want.cls) begin
          $error("temp_class mismatch: expected %0d, actual %0d", want.cls, out_tdata[7:6]);
          fail_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // register write, mirrored into the predictor
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [LIMIT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LOW_LIMIT:  low_lim  = val;
      REG_HIGH_LIMIT: high_lim = val;
      default: ;
    endcase
  endtask

  // mostly the band that spans every code, some full range and near full scale
  task automatic queue_random(int unsigned count);
    for (int unsigned n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: sample_q.push_back(ADC_W'($urandom_range(0, 1023)));
        3:       sample_q.push_back(ADC_W'($urandom_range(1016, 1023)));
        default: sample_q.push_back(ADC_W'($urandom_range(340, 790)));
      endcase
    end
  endtask

  // all items sent and every result back, then let the pipe settle
  task automatic wait_idle();
    while (sample_q.size() != 0 || in_tvalid || temp_exp_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(logic [LIMIT_W-1:0] lo, logic [LIMIT_W-1:0] hi,
                           int unsigned gap_max, int unsigned stall_max, bit squeeze);
    write_reg(REG_LOW_LIMIT, lo);
    write_reg(REG_HIGH_LIMIT, hi);
    send_gap_max   = gap_max;
    recv_stall_max = stall_max;
    queue_random(PHASE_ITEMS);
    if (squeeze) holds_asked++;
    wait_idle();
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // directed samples first, at the reset limits
    for (int i = 0; i < DIRECTED_N; i++)
      sample_q.push_back(DIRECTED_SAMPLES[i]);
    wait_idle();

    run_phase(6'd0,  6'd40, 4, 4, 1'b0);
    run_phase(6'd40, 6'd0,  0, 0, 1'b0);
    run_phase(6'd63, 6'd63, 0, 4, 1'b1);
    run_phase(6'd0,  6'd0,  4, 0, 1'b0);
    // writes to unused indexes must leave the limits alone
    write_reg(REG_SPARE_2, 6'd0);
    write_reg(REG_SPARE_3, 6'd63);
    run_phase(6'd30, 6'd10, 2, 2, 1'b0);
    run_phase(6'd20, 6'd63, 4, 4, 1'b1);
    run_phase(LIMIT_W'($urandom_range(0, 63)), LIMIT_W'($urandom_range(0, 63)),
              3, 3, 1'b0);
    run_phase(LIMIT_W'($urandom_range(0, 40)), LIMIT_W'($urandom_range(0, 40)),
              1, 4, 1'b0);
    run_phase(LOW_LIMIT_RESET, HIGH_LIMIT_RESET, 4, 1, 1'b0);

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
